@@ hdl/polyline_arc_length_lookup_assert.svh @@
// Assertion macros for the polyline arc-length lookup block.
`ifndef POLYLINE_ARC_LENGTH_LOOKUP_ASSERT_SVH
`define POLYLINE_ARC_LENGTH_LOOKUP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PAL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pal_pkg.sv @@
// Shared widths, codes and constants of the polyline arc-length lookup.
package pal_pkg;
  localparam int MAX_VERTICES = 256;
  localparam int COORD_BITS   = 24;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int LEN_W        = 40;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int SUM_W        = 2 * DIFF_W;
  localparam int ROOT_W       = DIFF_W;
  localparam int LOC_W        = 17;
  localparam int VTX_W        = 8;
  localparam int BLEND_W      = 17;
  localparam int ACTION_W     = 2;
  localparam int STATUS_W     = 2;

  localparam logic [LEN_W-1:0]   LEN_MAX = '1;
  localparam logic [BLEND_W-1:0] ONE_Q16 = 17'h10000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_START  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_SHORT = 2'd2
  } status_e;
endpackage

@@ hdl/pal_if.sv @@
// Handshake channel interfaces: vertex/query input, result output, configuration.
interface pal_in_if import pal_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [ACTION_W-1:0]          action;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic [LOC_W-1:0]             location;
  modport source (output valid, action, pos_x, pos_y, pos_z, location, input ready);
  modport sink (input valid, action, pos_x, pos_y, pos_z, location, output ready);
endinterface

interface pal_out_if import pal_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LEN_W-1:0]    total_length;
  logic [VTX_W-1:0]    lower_vertex;
  logic [VTX_W-1:0]    upper_vertex;
  logic [BLEND_W-1:0]  blend;
  logic [STATUS_W-1:0] status;
  modport source (output valid, total_length, lower_vertex, upper_vertex, blend, status,
                  input ready);
  modport sink (input valid, total_length, lower_vertex, upper_vertex, blend, status,
                output ready);
endinterface

interface pal_cfg_if ();
  logic valid;
  logic ready;
  logic closed_loop;
  modport source (output valid, closed_loop, input ready);
  modport sink (input valid, closed_loop, output ready);
endinterface

@@ hdl/pal_isqrt.sv @@
// Digit-recurrence integer square root, one root bit per cycle.
module pal_isqrt import pal_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  rad_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o
);
  localparam int REM_W  = ROOT_W + 3;
  localparam int ITER_W = $clog2(ROOT_W + 1);

  logic [SUM_W-1:0]  x_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [ITER_W-1:0] cnt_q;
  logic              busy_q;
  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;
  logic              ge;

  assign shifted = {rem_q[REM_W-3:0], x_q[SUM_W-1 -: 2]};
  assign trial   = REM_W'({root_q, 2'b01});
  assign ge      = shifted >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      x_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= ITER_W'(ROOT_W);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      x_q    <= {x_q[SUM_W-3:0], 2'b00};
      rem_q  <= ge ? shifted - trial : shifted;
      root_q <= {root_q[ROOT_W-2:0], ge};
      cnt_q  <= cnt_q - 1'b1;
      if (cnt_q == ITER_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;
endmodule

@@ hdl/pal_div.sv @@
// Restoring divider for the blend fraction, one quotient bit per cycle.
module pal_div import pal_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [LEN_W-1:0]   num_i,
  input  logic [LEN_W-1:0]   den_i,
  output logic               busy_o,
  output logic [BLEND_W-1:0] quot_o
);
  localparam int ITER_W = $clog2(BLEND_W + 1);

  logic [LEN_W:0]     rem_q;
  logic [LEN_W-1:0]   den_q;
  logic [BLEND_W-1:0] quot_q;
  logic [ITER_W-1:0]  cnt_q;
  logic               busy_q;
  logic               ge;
  logic [LEN_W:0]     rem_sub;

  // numerator never exceeds the divisor, so the remainder stays below twice it
  assign ge      = rem_q >= {1'b0, den_q};
  assign rem_sub = ge ? rem_q - {1'b0, den_q} : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      den_q  <= '0;
      quot_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
      cnt_q  <= ITER_W'(BLEND_W);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      rem_q  <= {rem_sub[LEN_W-1:0], 1'b0};
      quot_q <= {quot_q[BLEND_W-2:0], ge};
      cnt_q  <= cnt_q - 1'b1;
      if (cnt_q == ITER_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
endmodule

@@ hdl/polyline_arc_length_lookup.sv @@
// Polyline arc-length table and fractional lookup, sequenced over shared units.
// Start, unused action, dropped append, short query: result valid in the cycle after accept.
// Append: result after the segment pipeline (S_SEG) and the square root (S_ROOT).
// Query: closing root when looped, search probes on the table RAM, then the divide
// if the lower key is below the upper. One item at a time; ready only when idle.
// Reset clears counts, points and total; table contents stay undefined.
module polyline_arc_length_lookup import pal_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pal_in_if.sink     in_i,
  pal_out_if.source  res_o,
  pal_cfg_if.sink    cfg_i
);
  `include "polyline_arc_length_lookup_assert.svh"

  localparam int WORD_W = VTX_W + LEN_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SEG, S_ROOT, S_PREP, S_MUL, S_SRCH, S_SCMP,
    S_RDU, S_RDL, S_GETL, S_BLEND, S_DIV, S_OUT
  } state_e;

  state_e state_q;
  action_e act_q;
  logic signed [COORD_BITS-1:0] p_q     [3];
  logic signed [COORD_BITS-1:0] first_q [3];
  logic signed [COORD_BITS-1:0] prev_q  [3];
  logic [LOC_W-1:0]   loc_q;
  logic [CNT_W-1:0]   vc_q, ec_q, m_q, slo_q, shi_q, u_q, l_q;
  logic [LEN_W-1:0]   rt_q, ck_q, total_q, sample_q, hi_key_q, lo_key_q;
  logic               has_q, cl_q;
  logic [2:0]         step_q;
  logic [DIFF_W-1:0]  magd_q;
  logic [SUM_W-1:0]   sq_q, acc_q;
  logic [VTX_W-1:0]   uv_q, lv_q;
  logic               res_valid_q;
  logic [LEN_W-1:0]   res_total_q;
  logic [VTX_W-1:0]   res_lower_q, res_upper_q;
  logic [BLEND_W-1:0] res_blend_q;
  status_e            res_status_q;

  logic [WORD_W-1:0]  mem_q [MAX_VERTICES];
  logic [WORD_W-1:0]  rd_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [WORD_W-1:0]  mem_wdata;

  logic               accept;
  action_e            act_in;
  logic [LOC_W-1:0]   loc_in;
  logic signed [COORD_BITS-1:0] pin [3];
  logic [1:0]         axis;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]  mag;
  logic               sq_busy, div_busy, sq_start, div_start;
  logic [ROOT_W-1:0]  root;
  logic [BLEND_W-1:0] quot;
  logic [LEN_W:0]     nt_sum;
  logic [LEN_W-1:0]   nt;
  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid;
  logic [LEN_W+LOC_W-1:0] prod;
  logic [LEN_W-1:0]   vclamp;

  assign in_i.ready  = (state_q == S_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign act_in      = action_e'(in_i.action);
  assign loc_in      = (in_i.location > LOC_W'(ONE_Q16)) ? LOC_W'(ONE_Q16) : in_i.location;
  assign pin[0]      = in_i.pos_x;
  assign pin[1]      = in_i.pos_y;
  assign pin[2]      = in_i.pos_z;
  assign cfg_i.ready = 1'b1;

  // distance of one axis, closing segment against the first vertex
  assign axis = step_q[1:0];
  always_comb begin
    diff = '0;
    if (step_q < 3'd3) begin
      diff = DIFF_W'(prev_q[axis]) -
             DIFF_W'((act_q == ACT_QUERY) ? first_q[axis] : p_q[axis]);
    end
  end
  assign mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  assign sq_start  = (state_q == S_SEG) && (step_q == 3'd5);
  assign nt_sum    = {1'b0, rt_q} + (LEN_W+1)'(root);
  assign nt        = nt_sum[LEN_W] ? LEN_MAX : nt_sum[LEN_W-1:0];
  assign mid_sum   = {1'b0, slo_q} + {1'b0, shi_q};
  assign mid       = mid_sum[CNT_W:1];
  assign prod      = {{LOC_W{1'b0}}, total_q} * {{LEN_W{1'b0}}, loc_q};
  assign vclamp    = (sample_q < lo_key_q) ? lo_key_q :
                     ((sample_q > hi_key_q) ? hi_key_q : sample_q);
  assign div_start = (state_q == S_BLEND) && (lo_key_q < hi_key_q);

  pal_isqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(acc_q), .busy_o(sq_busy), .root_o(root)
  );

  pal_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(vclamp - lo_key_q),
    .den_i(hi_key_q - lo_key_q), .busy_o(div_busy), .quot_o(quot)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    if (accept && (act_in == ACT_START || (act_in == ACT_APPEND && vc_q == '0))) begin
      mem_we = 1'b1;
    end else if (state_q == S_ROOT && !sq_busy && act_q == ACT_APPEND && nt != rt_q) begin
      mem_we    = 1'b1;
      mem_waddr = ec_q[ADDR_W-1:0];
      mem_wdata = {VTX_W'(vc_q), nt};
    end
  end

  always_comb begin
    unique case (state_q)
      S_SRCH:  mem_raddr = mid[ADDR_W-1:0];
      S_RDU:   mem_raddr = u_q[ADDR_W-1:0];
      S_RDL:   mem_raddr = l_q[ADDR_W-1:0];
      default: mem_raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      act_q        <= ACT_NONE;
      p_q          <= '{default: '0};
      first_q      <= '{default: '0};
      prev_q       <= '{default: '0};
      loc_q        <= '0;
      vc_q         <= '0;
      ec_q         <= '0;
      m_q          <= '0;
      slo_q        <= '0;
      shi_q        <= '0;
      u_q          <= '0;
      l_q          <= '0;
      rt_q         <= '0;
      ck_q         <= '0;
      total_q      <= '0;
      sample_q     <= '0;
      hi_key_q     <= '0;
      lo_key_q     <= '0;
      has_q        <= 1'b0;
      cl_q         <= 1'b0;
      step_q       <= '0;
      magd_q       <= '0;
      sq_q         <= '0;
      acc_q        <= '0;
      uv_q         <= '0;
      lv_q         <= '0;
      res_valid_q  <= 1'b0;
      res_total_q  <= '0;
      res_lower_q  <= '0;
      res_upper_q  <= '0;
      res_blend_q  <= '0;
      res_status_q <= STAT_OK;
    end else begin
      if (cfg_i.valid) begin
        cl_q <= cfg_i.closed_loop;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            act_q        <= act_in;
            p_q          <= pin;
            loc_q        <= loc_in;
            step_q       <= '0;
            acc_q        <= '0;
            res_total_q  <= rt_q;
            res_lower_q  <= '0;
            res_upper_q  <= '0;
            res_blend_q  <= '0;
            res_status_q <= STAT_OK;
            if (act_in == ACT_START || (act_in == ACT_APPEND && vc_q == '0)) begin
              first_q     <= pin;
              prev_q      <= pin;
              vc_q        <= CNT_W'(1);
              ec_q        <= CNT_W'(1);
              rt_q        <= '0;
              res_total_q <= '0;
              res_valid_q <= 1'b1;
              state_q     <= S_OUT;
            end else if (act_in == ACT_APPEND) begin
              if (vc_q >= CNT_W'(MAX_VERTICES) || ec_q >= CNT_W'(MAX_VERTICES)) begin
                res_status_q <= STAT_FULL;
                res_valid_q  <= 1'b1;
                state_q      <= S_OUT;
              end else begin
                state_q <= S_SEG;
              end
            end else if (act_in == ACT_QUERY) begin
              if (vc_q < CNT_W'(2) || ec_q == '0) begin
                res_total_q  <= '0;
                res_status_q <= STAT_SHORT;
                res_valid_q  <= 1'b1;
                state_q      <= S_OUT;
              end else if (cl_q) begin
                state_q <= S_SEG;
              end else begin
                has_q   <= 1'b0;
                state_q <= S_PREP;
              end
            end else begin
              res_valid_q <= 1'b1;
              state_q     <= S_OUT;
            end
          end
        end
        S_SEG: begin
          // pipeline: axis difference, square, accumulate
          magd_q <= mag;
          sq_q   <= {{DIFF_W{1'b0}}, magd_q} * {{DIFF_W{1'b0}}, magd_q};
          if (step_q >= 3'd2 && step_q <= 3'd4) begin
            acc_q <= acc_q + sq_q;
          end
          step_q <= step_q + 1'b1;
          if (step_q == 3'd5) begin
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (!sq_busy) begin
            if (act_q == ACT_APPEND) begin
              if (nt != rt_q) begin
                ec_q <= ec_q + 1'b1;
              end
              rt_q        <= nt;
              prev_q      <= p_q;
              vc_q        <= vc_q + 1'b1;
              res_total_q <= nt;
              res_valid_q <= 1'b1;
              state_q     <= S_OUT;
            end else begin
              ck_q    <= nt;
              has_q   <= nt > rt_q;
              state_q <= S_PREP;
            end
          end
        end
        S_PREP: begin
          total_q <= has_q ? ck_q : rt_q;
          m_q     <= ec_q + CNT_W'(has_q);
          state_q <= S_MUL;
        end
        S_MUL: begin
          sample_q <= prod[LEN_W+15:16];
          slo_q    <= '0;
          shi_q    <= m_q - 1'b1;
          state_q  <= S_SRCH;
        end
        S_SRCH: begin
          if (slo_q < shi_q) begin
            state_q <= S_SCMP;
          end else begin
            u_q     <= slo_q;
            l_q     <= (slo_q == '0) ? m_q - 1'b1 : slo_q - 1'b1;
            state_q <= S_RDU;
          end
        end
        S_SCMP: begin
          if (rd_q[LEN_W-1:0] >= sample_q) begin
            shi_q <= mid;
          end else begin
            slo_q <= mid + 1'b1;
          end
          state_q <= S_SRCH;
        end
        S_RDU: begin
          state_q <= S_RDL;
        end
        S_RDL: begin
          hi_key_q <= (u_q < ec_q) ? rd_q[LEN_W-1:0] : ck_q;
          uv_q     <= (u_q < ec_q) ? rd_q[WORD_W-1:LEN_W] : '0;
          state_q  <= S_GETL;
        end
        S_GETL: begin
          lo_key_q <= (l_q < ec_q) ? rd_q[LEN_W-1:0] : ck_q;
          lv_q     <= (l_q < ec_q) ? rd_q[WORD_W-1:LEN_W] : '0;
          state_q  <= S_BLEND;
        end
        S_BLEND: begin
          res_total_q <= total_q;
          res_lower_q <= lv_q;
          res_upper_q <= uv_q;
          if (lo_key_q < hi_key_q) begin
            state_q <= S_DIV;
          end else begin
            res_blend_q <= (lo_key_q > hi_key_q) ? ONE_Q16 : '0;
            res_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            res_blend_q <= quot;
            res_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_o.ready) begin
            res_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.total_length = res_total_q;
  assign res_o.lower_vertex = res_lower_q;
  assign res_o.upper_vertex = res_upper_q;
  assign res_o.blend        = res_blend_q;
  assign res_o.status       = res_status_q;

  `PAL_ASSERT_IMP(a_busy_excl, res_valid_q, !in_i.ready, "input taken while result pending")
  `PAL_ASSERT_IMP(a_entry_le_vtx, 1'b1, ec_q <= vc_q, "entry count above vertex count")
  `PAL_ASSERT_IMP(a_blend_max, res_valid_q, res_blend_q <= ONE_Q16, "blend above one")
  `PAL_ASSERT_IMP(a_probe_range, state_q == S_SCMP, slo_q < shi_q && mid < ec_q,
                  "search probe outside table")
  `PAL_ASSERT_NXT(a_root_start, sq_start, sq_busy, "square root did not start")
endmodule
